// ===== rtl/core/local_minimum_counter_3x3_assert.svh =====
// assertion macros for the local minimum counter
// used by local_minimum_counter_3x3.sv, no other dependencies
`ifndef LOCAL_MINIMUM_COUNTER_3X3_ASSERT_SVH
`define LOCAL_MINIMUM_COUNTER_3X3_ASSERT_SVH

// same-cycle implication
`define LMC3_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lmc3: implication failed");

// next-cycle implication
`define LMC3_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lmc3: next-cycle check failed");

`endif

// ===== rtl/core/lmc3_pkg.sv =====
// shared types and constants for the local minimum counter
// no dependencies
`default_nettype none

package lmc3_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COUNT_W   = 21;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int INC_W     = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

	// one stored element: sample plus disqualify mark
	typedef struct packed {
		logic                       mark;
		logic signed [SAMPLE_W-1:0] value;
	} entry_t;

	// which neighbours exist for the incoming sample
	typedef struct packed {
		logic has_left;
		logic has_up;
		logic has_right;
	} nbr_t;

endpackage

`default_nettype wire

// ===== rtl/core/local_minimum_counter_3x3.sv =====
// a frame's count is registered as its last item leaves the item register
// throughput: one item per clock, sustained, also while a result waits on out_stall
// the only hold: last item of a frame while the previous count is still stalled
// reset: asynchronous, clears position, dq count, valids and frame size (1024 x 1024)
// line buffer contents are undefined after reset and need no clearing pass
// depends on lmc3_pkg, lmc3_cmp, lmc3_ram and the assertion macro header
`default_nettype none

`include "local_minimum_counter_3x3_assert.svh"

module local_minimum_counter_3x3 #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_wr_en,
	input  wire logic [lmc3_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [lmc3_pkg::CFG_W-1:0]            cfg_data,
	// sample stream
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [lmc3_pkg::SAMPLE_W-1:0]  sample,
	// per-frame result
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [lmc3_pkg::COUNT_W-1:0]               minima_count
);
	import lmc3_pkg::*;

	// widths: *_IW indexes a position, *_W holds a size up to the maximum
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = $clog2(MAX_COLS + 1);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int TW  = CW + RW;
	localparam int COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;
	localparam int ROWS_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
	localparam int EW  = $bits(entry_t);

	// frame size (clamped on write) and pixel count
	logic [CW-1:0] cols_q;
	logic [RW-1:0] rows_q;
	logic [TW-1:0] total_q;
	logic [CW-1:0] cols_wr;
	logic [RW-1:0] rows_wr;
	logic          cfg_hit;

	// position of the next item, input side
	logic [CIW-1:0] col_q;
	logic [RIW-1:0] row_q;
	logic [CW-1:0]  col_inc;
	logic [RW-1:0]  row_inc;
	logic           at_row_end;
	logic           at_frame_end;
	logic           accept;

	// stage 1: registered item and its neighbourhood flags
	logic                       vld_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [CIW-1:0]             col_s1;
	logic                       col_first_s1;
	logic                       row_first_s1;
	logic                       right_s1;
	logic                       frame_first_s1;
	logic                       last_s1;
	logic                       adv;
	logic                       out_free;

	// window: left element, upper row at c-1 and c, row-head and last write
	entry_t         left_q;
	logic [CIW-1:0] left_col_q;
	entry_t         win_a_q;
	entry_t         win_b_q;
	entry_t         head_q;
	entry_t         lastwr_q;

	logic [EW-1:0]  ram_rdata;
	entry_t         ram_rd;
	entry_t         up_m_in;
	entry_t         up_r_in;
	entry_t         left_upd;
	entry_t         up_m_upd;
	entry_t         up_r_upd;
	entry_t         wr_entry;
	nbr_t           nbr;
	logic           own;
	logic [INC_W-1:0] inc;
	logic           cols_is1;
	logic           cols_is2;
	logic           cols_is3;
	logic           ram_we;

	// disqualified elements so far and the result register
	logic [COUNT_W-1:0] dq_q;
	logic [COUNT_W-1:0] dq_next;
	logic [COUNT_W-1:0] result;
	logic               out_vld_q;
	logic [COUNT_W-1:0] minima_count_q;

	// ---------------------------------------------------------------
	// configuration: clamp to 1..max, any write restarts the frame
	// ---------------------------------------------------------------
	always_comb begin
		cols_wr = (cfg_data == '0) ? CW'(1) :
			(32'(cfg_data) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cfg_data);
		rows_wr = (cfg_data == '0) ? RW'(1) :
			(32'(cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg_data);
		case (cfg_index)
			REG_FRAME_COLS: cfg_hit = cfg_wr_en;
			REG_FRAME_ROWS: cfg_hit = cfg_wr_en;
			default:        cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CW'(COLS_RST);
			rows_q <= RW'(ROWS_RST);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_COLS: cols_q <= cols_wr;
				REG_FRAME_ROWS: rows_q <= rows_wr;
				default: ;
			endcase
		end
	end

	// pixel count is registered from the size, well before any frame end
	always_ff @(posedge clk) begin
		total_q <= TW'(cols_q) * TW'(rows_q);
	end

	// ---------------------------------------------------------------
	// handshake: the pipe only holds when a finished frame count meets
	// a result register that is full and stalled
	// ---------------------------------------------------------------
	always_comb begin
		out_free = !out_vld_q || !out_stall;
		adv      = vld_s1 && (!last_s1 || out_free);
		in_stall = vld_s1 && !adv;
		accept   = in_valid && !in_stall;
	end

	// ---------------------------------------------------------------
	// raster position of the next item
	// ---------------------------------------------------------------
	always_comb begin
		col_inc      = CW'(col_q) + CW'(1);
		row_inc      = RW'(row_q) + RW'(1);
		at_row_end   = (col_inc == cols_q);
		at_frame_end = at_row_end && (row_inc == rows_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_row_end) begin
				col_q <= '0;
				row_q <= at_frame_end ? '0 : RIW'(row_inc);
			end else begin
				col_q <= CIW'(col_inc);
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1: item register; the line buffer read of the upper-right
	// neighbour is issued at the same edge
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1      <= sample;
			col_s1         <= col_q;
			col_first_s1   <= (col_q == '0);
			row_first_s1   <= (row_q == '0);
			right_s1       <= !at_row_end;
			frame_first_s1 <= (col_q == '0) && (row_q == '0);
			last_s1        <= at_frame_end;
		end
	end

	// one line buffer, slot j holds the row above until the current row
	// overwrites it; an element is written one item after it arrives,
	// once its right-hand compare is done
	lmc3_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_COLS)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (left_col_q),
		.wdata (wr_entry),
		.re    (accept),
		.raddr (CIW'(col_inc)),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// stage 2: neighbour selection and compare
	// narrow frames: with one column the upper neighbour is the left
	// element still in flight; with two columns the upper-right one is;
	// with three columns the upper-right one may be written in the same
	// cycle as its read, so it comes from the last-write copy
	// ---------------------------------------------------------------
	always_comb begin
		cols_is1 = (cols_q == CW'(1));
		cols_is2 = (32'(cols_q) == 32'd2);
		cols_is3 = (32'(cols_q) == 32'd3);
		ram_rd   = entry_t'(ram_rdata);

		up_m_in = col_first_s1 ? (cols_is1 ? left_q : head_q) : win_b_q;
		up_r_in = cols_is2 ? left_q : (cols_is3 ? lastwr_q : ram_rd);

		nbr.has_left  = !col_first_s1;
		nbr.has_up    = !row_first_s1;
		nbr.has_right = right_s1;
	end

	lmc3_cmp u_cmp (
		.sample   (sample_s1),
		.nbr      (nbr),
		.left     (left_q),
		.up_l     (win_a_q),
		.up_m     (up_m_in),
		.up_r     (up_r_in),
		.left_upd (left_upd),
		.up_m_upd (up_m_upd),
		.up_r_upd (up_r_upd),
		.own      (own),
		.inc      (inc)
	);

	always_comb begin
		// left element goes to the line buffer with every mark it got here,
		// including the one it took as an aliased upper neighbour
		wr_entry.value = left_q.value;
		wr_entry.mark  = left_upd.mark
			| (col_first_s1 && cols_is1 && up_m_upd.mark)
			| (col_first_s1 && cols_is2 && up_r_upd.mark);
		// nothing valid to write at the first item of a frame
		ram_we  = adv && !frame_first_s1;

		dq_next = dq_q + COUNT_W'(inc);
		// a single-pixel frame has no neighbours and counts zero
		result  = (total_q > TW'(1)) ? (COUNT_W'(total_q) - dq_next) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_a_q    <= up_m_upd;
			win_b_q    <= up_r_upd;
			left_q     <= '{mark: own, value: sample_s1};
			left_col_q <= col_s1;
			if (!frame_first_s1) begin
				lastwr_q <= wr_entry;
				if (left_col_q == '0) begin
					head_q <= wr_entry;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// disqualified count and result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				dq_q <= '0;
			end else if (adv) begin
				dq_q <= last_s1 ? '0 : dq_next;
			end
			if (adv && last_s1) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			minima_count_q <= result;
		end
	end

	assign out_valid    = out_vld_q;
	assign minima_count = minima_count_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`LMC3_ASSERT_NEXT(a_frame_end_pos, clk, arst_n, accept && at_frame_end,
		(col_q == '0) && (row_q == '0))
	`LMC3_ASSERT_NEXT(a_count_cleared, clk, arst_n, adv && last_s1, dq_q == '0)
	`LMC3_ASSERT_IMPL(a_result_src, clk, arst_n, $rose(out_vld_q), $past(adv && last_s1))
	`LMC3_ASSERT_IMPL(a_hold_cause, clk, arst_n, in_stall,
		vld_s1 && last_s1 && out_vld_q && out_stall)

endmodule

`default_nettype wire

// ===== rtl/core/lmc3_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lmc3_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lmc3_cmp.sv =====
// neighbour compare for one incoming sample: marks, own mark, new-mark count
// depends on lmc3_pkg
`default_nettype none

module lmc3_cmp (
	input  wire logic signed [lmc3_pkg::SAMPLE_W-1:0] sample,
	input  wire lmc3_pkg::nbr_t                       nbr,
	input  wire lmc3_pkg::entry_t                     left,
	input  wire lmc3_pkg::entry_t                     up_l,
	input  wire lmc3_pkg::entry_t                     up_m,
	input  wire lmc3_pkg::entry_t                     up_r,
	output lmc3_pkg::entry_t                          left_upd,
	output lmc3_pkg::entry_t                          up_m_upd,
	output lmc3_pkg::entry_t                          up_r_upd,
	output logic                                      own,
	output logic [lmc3_pkg::INC_W-1:0]                inc
);
	import lmc3_pkg::*;

	logic use_l, use_ul, use_um, use_ur;
	logic set_l, set_ul, set_um, set_ur;
	logic own_l, own_ul, own_um, own_ur;

	always_comb begin
		use_l  = nbr.has_left;
		use_ul = nbr.has_left && nbr.has_up;
		use_um = nbr.has_up;
		use_ur = nbr.has_up && nbr.has_right;

		// neighbour loses when it is not strictly smaller, i.e. nv >= s
		set_l  = use_l  && !left.mark && (left.value >= sample);
		set_ul = use_ul && !up_l.mark && (up_l.value >= sample);
		set_um = use_um && !up_m.mark && (up_m.value >= sample);
		set_ur = use_ur && !up_r.mark && (up_r.value >= sample);

		own_l  = use_l  && (sample >= left.value);
		own_ul = use_ul && (sample >= up_l.value);
		own_um = use_um && (sample >= up_m.value);
		own_ur = use_ur && (sample >= up_r.value);
		own    = own_l || own_ul || own_um || own_ur;

		// the upper-left element has no later neighbour, only its count matters
		left_upd = '{mark: left.mark | set_l,  value: left.value};
		up_m_upd = '{mark: up_m.mark | set_um, value: up_m.value};
		up_r_upd = '{mark: up_r.mark | set_ur, value: up_r.value};

		inc = INC_W'(own) + INC_W'(set_l) + INC_W'(set_ul) + INC_W'(set_um)
			+ INC_W'(set_ur);
	end

endmodule

`default_nettype wire

// ===== verif/tb_local_minimum_counter_3x3.sv =====
// self-checking testbench for local_minimum_counter_3x3: directed and random frames against an inline predictor
// needs lmc3_pkg and the counter rtl, nothing else
`timescale 1ns / 100ps

module tb_local_minimum_counter_3x3;
	import lmc3_pkg::*;

	localparam int MAX_DIM       = 1024;
	// the count goes through the item register into the result register after the last item
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	// cycles with no handshake at all before the run is declared hung
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 780;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [CFG_W-1:0]           cfg_t;
	typedef logic [CFG_IDX_W-1:0]       reg_idx_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// how the samples of one frame are drawn
	typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EDGE, FILL_FLAT} fill_t;

	// tracks the frame as the block sees it and queues the count each frame must give
	class minima_predictor;
		int unsigned cols;
		int unsigned rows;
		sample_t     row_val  [2][MAX_DIM];
		bit          row_mark [2][MAX_DIM];
		int unsigned col_pos;
		int unsigned row_pos;
		int unsigned marked;
		count_t      pending_counts [$];
		int unsigned samples;
		int unsigned frames;
		int unsigned errors;

		function new();
			cols = MAX_DIM;
			rows = MAX_DIM;
			restart();
		endfunction

		function void restart();
			col_pos = 0;
			row_pos = 0;
			marked  = 0;
		endfunction

		// a size write clamps to 1..MAX_DIM and drops any partial frame
		function void set_size(reg_idx_t idx, cfg_t value);
			int unsigned v;
			v = (value == 0) ? 1 : (value > MAX_DIM) ? MAX_DIM : value;
			case (idx)
				REG_FRAME_COLS: cols = v;
				REG_FRAME_ROWS: rows = v;
				default: ;
			endcase
			restart();
		endfunction

		function void disqualify(bit b, int unsigned c);
			if (!row_mark[b][c]) begin
				row_mark[b][c] = 1'b1;
				marked++;
			end
		endfunction

		// the larger of the pair is out, a tie knocks out both
		function bit loses_to(sample_t s, bit b, int unsigned c);
			if (row_val[b][c] >= s)
				disqualify(b, c);
			return s >= row_val[b][c];
		endfunction

		function void note_sample(sample_t s);
			bit          cur;
			bit          lost;
			int unsigned total;
			cur  = row_pos[0];
			lost = 1'b0;
			samples++;
			if (col_pos > 0)
				lost |= loses_to(s, cur, col_pos - 1);
			if (row_pos > 0) begin
				lost |= loses_to(s, !cur, col_pos);
				if (col_pos > 0)
					lost |= loses_to(s, !cur, col_pos - 1);
				if (col_pos + 1 < cols)
					lost |= loses_to(s, !cur, col_pos + 1);
			end
			row_val[cur][col_pos]  = s;
			row_mark[cur][col_pos] = 1'b0;
			if (lost)
				disqualify(cur, col_pos);
			col_pos++;
			if (col_pos >= cols) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= rows) begin
				total = cols * rows;
				pending_counts.push_back((total > 1) ? count_t'(total - marked) : '0);
				restart();
			end
		endfunction

		function void check_count(count_t got);
			count_t want;
			frames++;
			if (pending_counts.size() == 0) begin
				$error("minima_count: expected none, actual %0d", got);
				errors++;
			end else begin
				want = pending_counts.pop_front();
				if (got !== want) begin
					$error("minima_count: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic     clk        = 1'b0;
	logic     arst_n     = 1'b0;
	logic     cfg_wr_en  = 1'b0;
	reg_idx_t cfg_index  = '0;
	cfg_t     cfg_data   = '0;
	logic     in_valid   = 1'b0;
	logic     in_stall;
	sample_t  sample     = '0;
	logic     out_valid;
	logic     out_stall  = 1'b0;
	count_t   minima_count;

	minima_predictor tally;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int unsigned items_sent  = 0;
	int unsigned size_writes = 0;
	int unsigned quiet_cycles = 0;

	local_minimum_counter_3x3 #(
		.MAX_COLS(MAX_DIM),
		.MAX_ROWS(MAX_DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.minima_count(minima_count)
	);

	always #2 clk = ~clk;

	// result side: random stall, and both channels watched at every rising edge
	// values read here are the ones from before the edge, so ordering within the step is moot
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n) begin
			// a count always comes from an earlier item, so check before noting the new one
			if (out_valid && !out_stall)
				tally.check_count(minima_count);
			if (in_valid && !in_stall)
				tally.note_sample(sample);
			if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// hang detector
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout after %0d cycles with no handshake", QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic sample_t pick_sample(fill_t fill, sample_t flat);
		case (fill)
			FILL_WIDE:   return sample_t'($urandom_range(65535));
			// tiny range, so ties are everywhere
			FILL_NARROW: return sample_t'($urandom_range(3) - 2);
			FILL_EDGE: begin
				case ($urandom_range(3))
					0:       return SAMPLE_MIN;
					1:       return SAMPLE_MAX;
					2:       return sample_t'(SAMPLE_MIN + 1);
					default: return sample_t'(SAMPLE_MAX - 1);
				endcase
			end
			default:     return flat;
		endcase
	endfunction

	// one item: random idle first, then hold until the block takes it
	task automatic push_sample(sample_t value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic push_frame(int unsigned n);
		fill_t       fill;
		sample_t     flat;
		int unsigned pick;
		pick = $urandom_range(99);
		fill = (pick < 40) ? FILL_WIDE : (pick < 70) ? FILL_NARROW :
			(pick < 85) ? FILL_EDGE : FILL_FLAT;
		flat = sample_t'($urandom_range(65535));
		repeat (n)
			push_sample(pick_sample(fill, flat));
	endtask

	// sender stops and waits for every outstanding count, always waiting on the clock before the first check
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tally.pending_counts.size() != 0);
	endtask

	// size writes only with the block idle; the SETTLE_CYCLES wait covers any item still in flight
	task automatic write_reg(reg_idx_t idx, cfg_t value);
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tally.set_size(idx, value);
		size_writes++;
	endtask

	// new size (one or both registers), a few whole frames, sometimes a cut-off frame
	task automatic run_group();
		int unsigned pick;
		int unsigned which;
		int unsigned total;
		cfg_t        wide;
		cfg_t        tall;
		pick = $urandom_range(99);
		if (pick < 60) begin
			wide = cfg_t'($urandom_range(6, 1));
			tall = cfg_t'($urandom_range(6, 1));
		end else if (pick < 85) begin
			wide = cfg_t'($urandom_range(24, 1));
			tall = cfg_t'($urandom_range(4, 1));
		end else begin
			wide = cfg_t'($urandom_range(3, 1));
			tall = cfg_t'($urandom_range(24, 1));
		end
		// zero is taken as one
		if ($urandom_range(19) == 0)
			wide = '0;
		if ($urandom_range(19) == 0)
			tall = '0;
		which = $urandom_range(2);
		// a size left over from a huge frame is always rewritten
		if (which != 2 || tally.cols > 24)
			write_reg(REG_FRAME_COLS, wide);
		if (which != 1 || tally.rows > 24)
			write_reg(REG_FRAME_ROWS, tall);
		total = tally.cols * tally.rows;
		repeat ($urandom_range(3, 1))
			push_frame(total);
		// partial frame, dropped by the next size write
		if (total > 1 && $urandom_range(9) == 0)
			push_frame($urandom_range(total - 1, 1));
	endtask

	// one idling mix: small random frames, then one wider or taller frame
	task automatic run_mode(int idle_pct, int stall_pct, cfg_t wide, cfg_t tall);
		int unsigned start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS / 3)
			run_group();
		write_reg(REG_FRAME_COLS, wide);
		write_reg(REG_FRAME_ROWS, tall);
		push_frame(tally.cols * tally.rows);
	endtask

	initial begin
		tally = new();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 14;
		recv_stall_pct = 88;

		// a few items into the 1024 x 1024 reset frame, then dropped by the size writes
		repeat (3)
			push_sample(pick_sample(FILL_WIDE, '0));

		// zero written to both: single-sample frames, never a minimum
		write_reg(REG_FRAME_COLS, '0);
		write_reg(REG_FRAME_ROWS, '0);
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MIN);

		// 3 x 3 with minima in three corners, extremes of the sample range included
		write_reg(REG_FRAME_COLS, 3);
		write_reg(REG_FRAME_ROWS, 3);
		push_sample(SAMPLE_MIN); push_sample(0);  push_sample(-5);
		push_sample(0);          push_sample(10); push_sample(0);
		push_sample(-7);         push_sample(0);  push_sample(SAMPLE_MAX);

		// one row of two: a tie knocks out both, then back to back a clear minimum
		write_reg(REG_FRAME_COLS, 2);
		write_reg(REG_FRAME_ROWS, 1);
		push_sample(4); push_sample(4);
		push_sample(3); push_sample(4);

		// single column, minimum in the middle
		write_reg(REG_FRAME_COLS, 1);
		write_reg(REG_FRAME_ROWS, 3);
		push_sample(1); push_sample(0); push_sample(1);

		// random part, each mix ending in one wider or taller frame
		run_mode(14, 88, 40, 3);
		run_mode(88, 14, 1, 40);
		run_mode(0, 0, 64, 2);

		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("%0d frame counts checked from %0d samples across %0d size writes",
			tally.frames, tally.samples, size_writes);
		$display("frames from one sample up to 64 wide and 40 tall, under three idle mixes");
		if (tally.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lmc3_pkg.sv
rtl/core/lmc3_ram.sv
rtl/core/lmc3_cmp.sv
rtl/core/local_minimum_counter_3x3.sv
verif/tb_local_minimum_counter_3x3.sv
